[src/jfr_pkg.sv]
// Shared constants and types for the joystick frame receiver.
// No dependencies; used by the channel interfaces and the top level.

package jfr_pkg;

   localparam int FRAME_BYTES = 9;
   localparam int TIMER_BITS  = 16;

   localparam int POS_BITS = 4;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = 16;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_TIMEOUT_MS   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_START_CHAR   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CENTER_VALUE = 2'd2;

   localparam logic [15:0] TIMEOUT_RESET = 16'd500;
   localparam logic [7:0]  START_RESET   = 8'd42;
   localparam logic [15:0] CENTER_RESET  = 16'd2047;
   localparam logic [7:0]  PREV_SEQ_RESET = 8'hFF;

   // input ops
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_REPEAT   = 2'd1;
   localparam logic [1:0] STATUS_CHECKSUM = 2'd2;
   localparam logic [1:0] STATUS_TIMEOUT  = 2'd3;

   // frame positions
   localparam logic [POS_BITS-1:0] POS_IDLE     = 4'd0;
   localparam logic [POS_BITS-1:0] POS_DIR_HI   = 4'd1;
   localparam logic [POS_BITS-1:0] POS_DIR_LO   = 4'd2;
   localparam logic [POS_BITS-1:0] POS_SPD_HI   = 4'd3;
   localparam logic [POS_BITS-1:0] POS_SPD_LO   = 4'd4;
   localparam logic [POS_BITS-1:0] POS_FLAGS_HI = 4'd5;
   localparam logic [POS_BITS-1:0] POS_FLAGS_LO = 4'd6;
   localparam logic [POS_BITS-1:0] POS_SEQ      = 4'd7;
   localparam logic [POS_BITS-1:0] POS_CHECKSUM = POS_BITS'(FRAME_BYTES - 1);

   typedef struct packed {
      logic [15:0] speed;
      logic [15:0] direction;
      logic        drive_mode;
      logic [1:0]  status;
   } rsp_item_type;

endpackage

[src/jfr_ifs.sv]
// Valid/ready channel interfaces of the joystick frame receiver.
// Depends on jfr_pkg for the register index and data widths.

interface jfr_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] rx_byte;
   modport source (output valid, op, rx_byte, input ready);
   modport sink   (input valid, op, rx_byte, output ready);
endinterface

interface jfr_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] speed;
   logic [15:0] direction;
   logic        drive_mode;
   logic [1:0]  status;
   modport source (output valid, speed, direction, drive_mode, status, input ready);
   modport sink   (input valid, speed, direction, drive_mode, status, output ready);
endinterface

interface jfr_csr_if;
   logic                              valid;
   logic                              ready;
   logic [jfr_pkg::CSR_IDX_BITS-1:0]  index;
   logic [jfr_pkg::CSR_DATA_BITS-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[src/joystick_frame_receiver.sv]
// Joystick frame receiver top level: frame decoder, link timer, result queue.
// Depends on jfr_pkg and the channel interfaces in jfr_ifs.sv.
//
// Takes one received byte or one millisecond tick per transfer on req_ch and
// can take a new transfer every clock cycle. An accepted item is registered,
// decoded in the following cycle, and its result (if any) is written into
// the result queue that drives rsp_ch. Results go through a two-entry queue,
// so input transfers continue while a result waits; the input stalls only
// when the results still queued plus the item in the decode register would
// fill both queue entries. Registers on csr_ch are always ready, and a write
// is stored in its configuration register.

module joystick_frame_receiver #(
   parameter int TIMER_BITS = jfr_pkg::TIMER_BITS
) (
   input logic        clock,
   input logic        reset,
   jfr_req_if.sink    req_ch,
   jfr_rsp_if.source  rsp_ch,
   jfr_csr_if.sink    csr_ch
);

   localparam int CMP_BITS = (TIMER_BITS > 16) ? TIMER_BITS : 16;

   // configuration
   logic [15:0] timeout_ms_ff;
   logic [7:0]  start_char_ff;
   logic [15:0] center_value_ff;

   // decode register
   logic       s1_valid_ff;
   logic       s1_op_ff;
   logic [7:0] s1_byte_ff;

   // frame state
   logic [jfr_pkg::POS_BITS-1:0] pos_ff, pos_in;
   logic [7:0]  sum_ff, sum_in;
   logic [15:0] dir_ff, dir_in;
   logic [15:0] spd_ff, spd_in;
   logic        mode_ff, mode_in;
   logic [7:0]  seq_ff, seq_in;
   logic [7:0]  prev_seq_ff, prev_seq_in;
   logic [TIMER_BITS-1:0] elapsed_ff, elapsed_in;

   // result queue
   jfr_pkg::rsp_item_type q_ff [2];
   logic       q_wr_ptr_ff, q_rd_ptr_ff;
   logic [1:0] q_cnt_ff;

   jfr_pkg::rsp_item_type res;
   logic push, pop, accept;
   logic [2:0] committed;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ms_ff   <= jfr_pkg::TIMEOUT_RESET;
         start_char_ff   <= jfr_pkg::START_RESET;
         center_value_ff <= jfr_pkg::CENTER_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            jfr_pkg::CSR_TIMEOUT_MS:   timeout_ms_ff   <= csr_ch.data;
            jfr_pkg::CSR_START_CHAR:   start_char_ff   <= csr_ch.data[7:0];
            jfr_pkg::CSR_CENTER_VALUE: center_value_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // input handshake
   assign pop       = rsp_ch.valid && rsp_ch.ready;
   assign committed = 3'(q_cnt_ff) + 3'(s1_valid_ff) - 3'(pop);
   assign req_ch.ready = (committed <= 3'd1);
   assign accept    = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      if (accept) begin
         s1_op_ff   <= req_ch.op;
         s1_byte_ff <= req_ch.rx_byte;
      end
   end

   // decode
   always_comb begin
      pos_in      = pos_ff;
      sum_in      = sum_ff;
      dir_in      = dir_ff;
      spd_in      = spd_ff;
      mode_in     = mode_ff;
      seq_in      = seq_ff;
      prev_seq_in = prev_seq_ff;
      elapsed_in  = elapsed_ff;
      push        = 1'b0;
      res.speed      = center_value_ff;
      res.direction  = center_value_ff;
      res.drive_mode = 1'b0;
      res.status     = jfr_pkg::STATUS_TIMEOUT;
      if (s1_valid_ff) begin
         if (s1_op_ff == jfr_pkg::OP_TICK) begin
            if (elapsed_ff != {TIMER_BITS{1'b1}}) begin
               elapsed_in = elapsed_ff + 1'b1;
            end
            if (CMP_BITS'(elapsed_in) > CMP_BITS'(timeout_ms_ff)) begin
               push = 1'b1;
            end
         end else begin
            if (pos_ff >= jfr_pkg::POS_DIR_HI && pos_ff <= jfr_pkg::POS_SEQ) begin
               sum_in = sum_ff + s1_byte_ff;
            end
            pos_in = pos_ff + 1'b1;
            case (pos_ff)
               jfr_pkg::POS_IDLE: begin
                  if (s1_byte_ff == start_char_ff) begin
                     sum_in = '0;
                  end else begin
                     pos_in = jfr_pkg::POS_IDLE;
                  end
               end
               jfr_pkg::POS_DIR_HI:   dir_in = {s1_byte_ff, dir_ff[7:0]};
               jfr_pkg::POS_DIR_LO:   dir_in = {dir_ff[15:8], s1_byte_ff};
               jfr_pkg::POS_SPD_HI:   spd_in = {s1_byte_ff, spd_ff[7:0]};
               jfr_pkg::POS_SPD_LO:   spd_in = {spd_ff[15:8], s1_byte_ff};
               jfr_pkg::POS_FLAGS_HI: ;
               jfr_pkg::POS_FLAGS_LO: mode_in = s1_byte_ff[0];
               jfr_pkg::POS_SEQ:      seq_in = s1_byte_ff;
               jfr_pkg::POS_CHECKSUM: begin
                  pos_in = jfr_pkg::POS_IDLE;
                  push   = 1'b1;
                  if (seq_ff == prev_seq_ff) begin
                     res.status = jfr_pkg::STATUS_REPEAT;
                  end else begin
                     prev_seq_in = seq_ff;
                     if (s1_byte_ff != sum_ff) begin
                        res.status = jfr_pkg::STATUS_CHECKSUM;
                     end else begin
                        elapsed_in     = '0;
                        res.speed      = spd_ff;
                        res.direction  = dir_ff;
                        res.drive_mode = mode_ff;
                        res.status     = jfr_pkg::STATUS_OK;
                     end
                  end
               end
               default: pos_in = jfr_pkg::POS_IDLE;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= jfr_pkg::POS_IDLE;
         sum_ff      <= '0;
         dir_ff      <= '0;
         spd_ff      <= '0;
         mode_ff     <= 1'b0;
         seq_ff      <= '0;
         prev_seq_ff <= jfr_pkg::PREV_SEQ_RESET;
         elapsed_ff  <= '0;
      end else begin
         pos_ff      <= pos_in;
         sum_ff      <= sum_in;
         dir_ff      <= dir_in;
         spd_ff      <= spd_in;
         mode_ff     <= mode_in;
         seq_ff      <= seq_in;
         prev_seq_ff <= prev_seq_in;
         elapsed_ff  <= elapsed_in;
      end
   end

   // result queue
   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ptr_ff <= 1'b0;
         q_rd_ptr_ff <= 1'b0;
         q_cnt_ff    <= '0;
      end else begin
         if (push) q_wr_ptr_ff <= ~q_wr_ptr_ff;
         if (pop)  q_rd_ptr_ff <= ~q_rd_ptr_ff;
         q_cnt_ff <= q_cnt_ff + 2'(push) - 2'(pop);
      end
      if (push) begin
         q_ff[q_wr_ptr_ff] <= res;
      end
   end

   assign rsp_ch.valid      = (q_cnt_ff != 2'd0);
   assign rsp_ch.speed      = q_ff[q_rd_ptr_ff].speed;
   assign rsp_ch.direction  = q_ff[q_rd_ptr_ff].direction;
   assign rsp_ch.drive_mode = q_ff[q_rd_ptr_ff].drive_mode;
   assign rsp_ch.status     = q_ff[q_rd_ptr_ff].status;

   // checks
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && q_cnt_ff == 2'd2))
      else $error("result queue overflow");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      q_cnt_ff <= 2'd2)
      else $error("result queue count out of range");

   a_good_clears_timer: assert property (@(posedge clock) disable iff (reset)
      push && res.status == jfr_pkg::STATUS_OK |=> elapsed_ff == '0)
      else $error("link timer not cleared by good frame");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= jfr_pkg::POS_CHECKSUM)
      else $error("frame position out of range");

endmodule
